// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checks in src/dbic_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, held off while reset is high.
`define DBIC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: %m");

// Concurrent assertion that is also checked through reset.
`define DBIC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed: %m");

`endif

// ===== src/dbic_pkg.sv =====
// Types, codes and byte helpers for the dual bank interrupt controller.
// No dependencies.
package dbic_pkg;

   typedef enum logic [2:0] {
      OP_BUS_READ   = 3'd0,
      OP_BUS_WRITE  = 3'd1,
      OP_PRIV_WRITE = 3'd2,
      OP_LINE_LEVEL = 3'd3,
      OP_LINE_PULSE = 3'd4
   } op_type;

   // Register codes within a bank: address bits 4..2.
   typedef enum logic [2:0] {
      REG_STATUS = 3'd0,
      REG_ENABLE = 3'd1,
      REG_ACK    = 3'd2,
      REG_LATCH  = 3'd3,
      REG_INVERT = 3'd4,
      REG_MASKED = 3'd5
   } reg_type;

   localparam logic [5:0]  IDX_REVISION  = 6'd20;
   localparam logic [5:0]  IDX_SRC_COUNT = 6'd21;
   localparam logic [31:0] REVISION_WORD = 32'h0001_0900;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] address;
      logic [7:0] write_data;
      logic [4:0] source_line;
      logic       line_level;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] pending;
   } result_type;

   function automatic logic [7:0] byte_of(input logic [31:0] word, input logic [1:0] sel);
      logic [31:0] s;
      s = word >> {sel, 3'b000};
      return s[7:0];
   endfunction

   function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] sel,
                                            input logic [7:0] v);
      logic [31:0] mask;
      mask = 32'h0000_00FF << {sel, 3'b000};
      return (word & ~mask) | ({24'h0, v} << {sel, 3'b000});
   endfunction

endpackage

// ===== src/dbic_req_if.sv =====
// Request channel: valid/ready plus one controller transaction.
// Depends on dbic_pkg.
interface dbic_req_if;
   import dbic_pkg::*;

   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [7:0] address;
   logic [7:0] write_data;
   logic [4:0] source_line;
   logic       line_level;

   modport source (output valid, operation, address, write_data, source_line, line_level,
                   input ready);
   modport sink (input valid, operation, address, write_data, source_line, line_level,
                 output ready);
endinterface

// ===== src/dbic_rsp_if.sv =====
// Response channel: valid/ready plus read byte and per-bank pending flags.
// Depends on dbic_pkg.
interface dbic_rsp_if;
   import dbic_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [1:0] pending;

   modport source (output valid, read_data, pending, input ready);
   modport sink (input valid, read_data, pending, output ready);
endinterface

// ===== src/dbic_regs.sv =====
// Register banks and the read/modify/write logic for one transaction.
// Depends on dbic_pkg.
module dbic_regs #(
   parameter int POWER_SOURCE_BIT = 15,
   parameter int SOURCE_COUNT     = 22
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 upd_en,
   input  dbic_pkg::item_type   item,
   output dbic_pkg::result_type result
);
   import dbic_pkg::*;

   localparam logic [31:0] POWER_MASK =
      (POWER_SOURCE_BIT < SOURCE_COUNT) ? (32'h1 << POWER_SOURCE_BIT) : 32'h0;

   logic [31:0] status_ff [2];
   logic [31:0] enable_ff [2];
   logic [31:0] latch_ff  [2];
   logic [31:0] invert_ff [2];
   logic [31:0] status_in [2];
   logic [31:0] enable_in [2];
   logic [31:0] latch_in  [2];
   logic [31:0] invert_in [2];

   logic [5:0]  idx;
   logic        bsel;
   logic [1:0]  bsub;
   logic        bank_hit;
   logic [31:0] line_mask;
   logic [31:0] shifted;
   logic [7:0]  rd;

   assign idx      = item.address[7:2];
   assign bsel     = item.address[5];
   assign bsub     = item.address[1:0];
   assign bank_hit = (idx[5:4] == 2'b00);
   assign shifted  = {24'h0, item.write_data} << {bsub, 3'b000};
   assign line_mask = ({1'b0, item.source_line} < 6'(SOURCE_COUNT)) ?
                      (32'h1 << item.source_line) : 32'h0;

   always_comb begin
      rd = 8'h00;
      for (int b = 0; b < 2; b++) begin
         status_in[b] = status_ff[b];
         enable_in[b] = enable_ff[b];
         latch_in[b]  = latch_ff[b];
         invert_in[b] = invert_ff[b];
      end

      case (item.operation)
         OP_BUS_READ: begin
            if (bank_hit) begin
               case (idx[2:0])
                  REG_STATUS: rd = byte_of(status_ff[bsel], bsub);
                  REG_ENABLE: rd = byte_of(enable_ff[bsel], bsub);
                  REG_LATCH:  rd = byte_of(latch_ff[bsel], bsub);
                  REG_INVERT: rd = byte_of(invert_ff[bsel], bsub);
                  REG_MASKED: rd = byte_of(status_ff[bsel] & enable_ff[bsel], bsub);
                  default:    rd = 8'h00;
               endcase
            end else if (idx == IDX_REVISION) begin
               rd = byte_of(REVISION_WORD, bsub);
            end else if (idx == IDX_SRC_COUNT) begin
               rd = bsub[1] ? 8'h00 : 8'(SOURCE_COUNT);
            end
         end
         OP_BUS_WRITE, OP_PRIV_WRITE: begin
            if (bank_hit) begin
               case (idx[2:0])
                  REG_STATUS: begin
                     if (item.operation == OP_PRIV_WRITE) begin
                        status_in[bsel] = put_byte(status_ff[bsel], bsub, item.write_data);
                     end
                  end
                  REG_ENABLE:
                     enable_in[bsel] = put_byte(enable_ff[bsel], bsub, item.write_data);
                  REG_ACK:
                     status_in[bsel] = status_ff[bsel] & ~(shifted & latch_ff[bsel]);
                  REG_LATCH:
                     latch_in[bsel] = put_byte(latch_ff[bsel], bsub, item.write_data);
                  REG_INVERT:
                     invert_in[bsel] = put_byte(invert_ff[bsel], bsub, item.write_data);
                  REG_MASKED: begin
                     if (item.operation == OP_PRIV_WRITE) begin
                        enable_in[bsel] = enable_ff[bsel] | shifted;
                        status_in[bsel] = status_ff[bsel] | shifted;
                     end
                  end
                  default: ;
               endcase
            end
         end
         OP_LINE_LEVEL: begin
            // active (level xor invert) sets the bit, otherwise only latched bits survive
            for (int b = 0; b < 2; b++) begin
               status_in[b] = (status_ff[b] & ~line_mask) |
                              (line_mask & (({32{item.line_level}} ^ invert_ff[b]) |
                                            (status_ff[b] & latch_ff[b])));
            end
         end
         OP_LINE_PULSE: begin
            // high then low: ends set if inverted or latched
            for (int b = 0; b < 2; b++) begin
               status_in[b] = (status_ff[b] & ~line_mask) |
                              (line_mask & (invert_ff[b] | latch_ff[b]));
            end
         end
         default: ;
      endcase

      result.read_data  = rd;
      result.pending[0] = |(status_in[0] & enable_in[0]);
      result.pending[1] = |(status_in[1] & enable_in[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < 2; b++) begin
            status_ff[b] <= POWER_MASK;
            enable_ff[b] <= 32'h0;
            latch_ff[b]  <= 32'h0;
            invert_ff[b] <= 32'h0;
         end
      end else if (upd_en) begin
         for (int b = 0; b < 2; b++) begin
            status_ff[b] <= status_in[b];
            enable_ff[b] <= enable_in[b];
            latch_ff[b]  <= latch_in[b];
            invert_ff[b] <= invert_in[b];
         end
      end
   end

endmodule

// ===== src/dual_bank_interrupt_controller.sv =====
// Top level of the dual bank interrupt controller: input register, register
// banks (dbic_regs) and output register. Depends on dbic_pkg and the channel interfaces.
//
//   channel | direction | payload
//   req_ch  | in        | operation, address, write_data, source_line, line_level
//   rsp_ch  | out       | read_data, pending
//
// One transaction per cycle sustained while rsp is not stalled; an accepted req passes
// through the input register and then the output register before rsp valid rises.
// The banks are read, modified and written in the single cycle a transaction leaves the
// input register, so back-to-back line events and bus accesses see each other in order.
// Reset (synchronous) empties both registers and loads the power-on status bit.
// A stalled rsp holds its output register; req stays ready as long as the input register
// can move on, so the only stall upstream is a full input register behind a stalled rsp.
module dual_bank_interrupt_controller #(
   parameter int POWER_SOURCE_BIT = 15,
   parameter int SOURCE_COUNT     = 22
) (
   input logic        clock,
   input logic        reset,
   dbic_req_if.sink   req_ch,
   dbic_rsp_if.source rsp_ch
);
   import dbic_pkg::*;

   // Input register
   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   item_type   req_item;

   // Output register
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;
   result_type step_result;

   logic       req_accept;
   logic       advance;

   assign req_item = '{operation:   req_ch.operation,
                       address:     req_ch.address,
                       write_data:  req_ch.write_data,
                       source_line: req_ch.source_line,
                       line_level:  req_ch.line_level};

   // The held transaction moves into the banks when the output slot is free or draining.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   dbic_regs #(
      .POWER_SOURCE_BIT (POWER_SOURCE_BIT),
      .SOURCE_COUNT     (SOURCE_COUNT)
   ) u_regs (
      .clock  (clock),
      .reset  (reset),
      .upd_en (advance),
      .item   (in_item_ff),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.read_data = out_ff.read_data;
   assign rsp_ch.pending   = out_ff.pending;

endmodule

// ===== src/dbic_checker.sv =====
// Port-level checks for the dual bank interrupt controller, bound to the top level.
// Depends on dbic_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dbic_assertions (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [2:0] req_operation,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic [1:0] rsp_pending
);
   import dbic_pkg::*;

   logic       rsp_stall;
   logic       req_nonread;
   logic       rsp_zero;
   logic [9:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign req_nonread = req_valid && req_ready && (req_operation != OP_BUS_READ);
   assign rsp_zero    = rsp_valid && (rsp_read_data == 8'h00);
   assign rsp_payload = {rsp_read_data, rsp_pending};

   // A stalled response keeps its contents.
   `DBIC_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // Request side only backs off behind a stalled response.
   `DBIC_ASSERT(a_ready_low_only_on_stall, clock, reset, !req_ready |-> rsp_stall)

   // Anything but a bus read answers with a zero byte, given rsp is not stalled.
   `DBIC_ASSERT(a_nonread_zero, clock, reset, req_nonread ##1 !rsp_stall |=> rsp_zero)

   // Reset drops any pending response.
   `DBIC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind dual_bank_interrupt_controller dbic_assertions u_dbic_assertions (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_operation (req_ch.operation),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_read_data (rsp_ch.read_data),
   .rsp_pending   (rsp_ch.pending)
);

// ===== bench/dbic_checker.sv =====
// Checker for the dual bank interrupt controller: keeps its own copy of both
// register banks, forecasts every response and compares it as it leaves.
// Depends on dbic_pkg.
module dbic_checker #(
   parameter int POWER_SOURCE_BIT = 15,
   parameter int SOURCE_COUNT     = 22
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [2:0] req_operation,
   input  logic [7:0] req_address,
   input  logic [7:0] req_write_data,
   input  logic [4:0] req_source_line,
   input  logic       req_line_level,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_read_data,
   input  logic [1:0] rsp_pending,
   output int         error_count,
   output int         open_results
);
   import dbic_pkg::*;

   logic [31:0] irq_status [2];
   logic [31:0] irq_enable [2];
   logic [31:0] irq_latch  [2];
   logic [31:0] irq_invert [2];

   result_type rsp_forecast [$];
   result_type fresh_rsp;
   result_type oldest_rsp;

   // Drive one source line in both banks; invert is per bit, latch holds a set bit.
   task automatic drive_source(input logic [31:0] line_bit, input logic lvl);
      for (int b = 0; b < 2; b++) begin
         if ((((lvl ? line_bit : 32'h0) ^ (irq_invert[b] & line_bit))) != 32'h0)
            irq_status[b] |= line_bit;
         else
            irq_status[b] &= ~line_bit | irq_latch[b];
      end
   endtask

   task automatic step_controller(input logic [2:0] op, input logic [7:0] addr,
                                  input logic [7:0] wdata, input logic [4:0] line,
                                  input logic lvl, output result_type res);
      logic [31:0] line_bit;
      logic [31:0] lane;
      logic [31:0] lane_mask;
      logic [31:0] word;
      logic [4:0]  shift;
      logic        bank;
      logic        priv;
      logic        in_bank;
      reg_type     rsel;
      line_bit  = (int'(line) < SOURCE_COUNT) ? (32'h1 << line) : 32'h0;
      shift     = {addr[1:0], 3'b000};
      lane      = {24'h0, wdata} << shift;
      lane_mask = 32'h0000_00FF << shift;
      bank      = addr[5];
      in_bank   = (addr[7:6] == 2'b00);
      rsel      = reg_type'(addr[4:2]);
      priv      = (op == OP_PRIV_WRITE);
      word      = 32'h0;
      res.read_data = 8'h00;
      case (op)
         OP_BUS_READ: begin
            if (in_bank) begin
               case (rsel)
                  REG_STATUS: word = irq_status[bank];
                  REG_ENABLE: word = irq_enable[bank];
                  REG_LATCH:  word = irq_latch[bank];
                  REG_INVERT: word = irq_invert[bank];
                  REG_MASKED: word = irq_status[bank] & irq_enable[bank];
                  default:    word = 32'h0;
               endcase
            end else if (addr[7:2] == IDX_REVISION) begin
               word = REVISION_WORD;
            end else if (addr[7:2] == IDX_SRC_COUNT) begin
               word = {16'h0, 8'(SOURCE_COUNT), 8'(SOURCE_COUNT)};
            end
            word = word >> shift;
            res.read_data = word[7:0];
         end
         OP_BUS_WRITE, OP_PRIV_WRITE: begin
            if (in_bank) begin
               case (rsel)
                  REG_STATUS: if (priv)
                     irq_status[bank] = (irq_status[bank] & ~lane_mask) | lane;
                  REG_ENABLE: irq_enable[bank] = (irq_enable[bank] & ~lane_mask) | lane;
                  REG_ACK:    irq_status[bank] &= ~(lane & irq_latch[bank]);
                  REG_LATCH:  irq_latch[bank]  = (irq_latch[bank] & ~lane_mask) | lane;
                  REG_INVERT: irq_invert[bank] = (irq_invert[bank] & ~lane_mask) | lane;
                  REG_MASKED: if (priv) begin
                     irq_enable[bank] |= lane;
                     irq_status[bank] |= lane;
                  end
                  default: ;
               endcase
            end
         end
         OP_LINE_LEVEL: drive_source(line_bit, lvl);
         OP_LINE_PULSE: begin
            drive_source(line_bit, 1'b1);
            drive_source(line_bit, 1'b0);
         end
         default: ;
      endcase
      res.pending = {|(irq_status[1] & irq_enable[1]), |(irq_status[0] & irq_enable[0])};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < 2; b++) begin
            irq_status[b] = 32'h0;
            irq_enable[b] = 32'h0;
            irq_latch[b]  = 32'h0;
            irq_invert[b] = 32'h0;
         end
         drive_source((POWER_SOURCE_BIT < SOURCE_COUNT) ? (32'h1 << POWER_SOURCE_BIT) : 32'h0,
                      1'b1);
         rsp_forecast.delete();
         error_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            step_controller(req_operation, req_address, req_write_data, req_source_line,
                            req_line_level, fresh_rsp);
            rsp_forecast.push_back(fresh_rsp);
         end
         if (rsp_valid && rsp_ready) begin
            if (rsp_forecast.size() == 0) begin
               error_count++;
               $display("%0t: response with no transaction outstanding, actual %02h/%b",
                        $time, rsp_read_data, rsp_pending);
            end else begin
               oldest_rsp = rsp_forecast.pop_front();
               if (rsp_read_data !== oldest_rsp.read_data) begin
                  error_count++;
                  $display("%0t: read_data mismatch, expected %02h, actual %02h",
                           $time, oldest_rsp.read_data, rsp_read_data);
               end
               if (rsp_pending !== oldest_rsp.pending) begin
                  error_count++;
                  $display("%0t: pending mismatch, expected %b, actual %b",
                           $time, oldest_rsp.pending, rsp_pending);
               end
            end
         end
      end
      open_results = rsp_forecast.size();
   end

endmodule

// ===== bench/tb_dual_bank_interrupt_controller.sv =====
// Top of the interrupt controller bench: clock, reset, transaction stimulus and
// response back-pressure, with dbic_checker watching both channels.
// Depends on dbic_pkg, the channel interfaces, dbic_checker and the block.
module tb_dual_bank_interrupt_controller;
   import dbic_pkg::*;

   localparam int POWER_BIT     = 15;
   localparam int SRC_COUNT     = 22;
   localparam int PHASE_ITEMS   = 325;     // random transactions per idling phase
   localparam int LONG_STALL    = 300;     // cycles the receiver holds off once
   localparam int LIMIT_TIME    = 2000000; // far beyond the slowest legal run

   // Spare operation codes; the block must treat them as no-ops.
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   logic clock;
   logic reset;

   int send_idle_pct;
   int recv_idle_pct;
   int stall_requests;   // bumped by the sender, served by the receiver loop
   int error_count;
   int open_results;

   dbic_req_if req_ch ();
   dbic_rsp_if rsp_ch ();

   dual_bank_interrupt_controller #(
      .POWER_SOURCE_BIT(POWER_BIT),
      .SOURCE_COUNT(SRC_COUNT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   dbic_checker #(
      .POWER_SOURCE_BIT(POWER_BIT),
      .SOURCE_COUNT(SRC_COUNT)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_operation(req_ch.operation),
      .req_address(req_ch.address),
      .req_write_data(req_ch.write_data),
      .req_source_line(req_ch.source_line),
      .req_line_level(req_ch.line_level),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_read_data(rsp_ch.read_data),
      .rsp_pending(rsp_ch.pending),
      .error_count(error_count),
      .open_results(open_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop; a hang or a lost response ends up here.
   initial begin
      #(LIMIT_TIME);
      $display("Regression FAIL");
      $finish;
   end

   // Byte address of a bank register.
   function automatic logic [7:0] reg_addr(input logic bank, input reg_type rsel,
                                           input logic [1:0] sel);
      return {2'b00, bank, rsel, sel};
   endfunction

   function automatic item_type make_item(input logic [2:0] op, input logic [7:0] addr,
                                          input logic [7:0] wdata, input logic [4:0] line,
                                          input logic lvl);
      item_type it;
      it.operation   = op;
      it.address     = addr;
      it.write_data  = wdata;
      it.source_line = line;
      it.line_level  = lvl;
      return it;
   endfunction

   // Called at a falling edge, returns at a falling edge. Valid stays high from
   // one transaction to the next unless an idle cycle is drawn, so each step
   // sees a single assignment to valid.
   task automatic send_item(input item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= it.operation;
      req_ch.address     <= it.address;
      req_ch.write_data  <= it.write_data;
      req_ch.source_line <= it.source_line;
      req_ch.line_level  <= it.line_level;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Response back-pressure: random idling, plus one long hold-off on request
   // so the input register fills and req.ready drops.
   initial begin : receiver
      int stall_served;
      int hold_left;
      stall_served = 0;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && stall_served != stall_requests) begin
            hold_left = LONG_STALL;
            stall_served++;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : stimulus
      item_type it;
      int pick;
      send_idle_pct      = 0;
      recv_idle_pct      = 0;
      stall_requests     = 0;
      req_ch.valid       = 1'b0;
      req_ch.operation   = OP_BUS_READ;
      req_ch.address     = 8'h00;
      req_ch.write_data  = 8'h00;
      req_ch.source_line = 5'd0;
      req_ch.line_level  = 1'b0;
      reset              = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part ----
      // Power-on value: only the power source bit set, in both banks.
      send_item(make_item(OP_BUS_READ, reg_addr(1'b0, REG_STATUS, 2'd1), 8'h00, 5'd0, 1'b0));
      send_item(make_item(OP_BUS_READ, reg_addr(1'b1, REG_STATUS, 2'd1), 8'h00, 5'd0, 1'b0));
      // Revision word, all four bytes; source count, low and high half.
      send_item(make_item(OP_BUS_READ, {IDX_REVISION, 2'd0}, 8'h00, 5'd0, 1'b0));
      send_item(make_item(OP_BUS_READ, {IDX_REVISION, 2'd1}, 8'h00, 5'd0, 1'b0));
      send_item(make_item(OP_BUS_READ, {IDX_REVISION, 2'd2}, 8'h00, 5'd0, 1'b0));
      send_item(make_item(OP_BUS_READ, {IDX_REVISION, 2'd3}, 8'h00, 5'd0, 1'b0));
      send_item(make_item(OP_BUS_READ, {IDX_SRC_COUNT, 2'd0}, 8'h00, 5'd0, 1'b0));
      send_item(make_item(OP_BUS_READ, {IDX_SRC_COUNT, 2'd2}, 8'h00, 5'd0, 1'b0));
      // Unmapped read and unmapped write.
      send_item(make_item(OP_BUS_READ, 8'hFF, 8'h00, 5'd0, 1'b0));
      send_item(make_item(OP_PRIV_WRITE, 8'hFF, 8'hFF, 5'd0, 1'b0));
      // Plain write to status is dropped; the privileged one lands.
      send_item(make_item(OP_BUS_WRITE, reg_addr(1'b0, REG_STATUS, 2'd0), 8'hFF, 5'd0, 1'b0));
      send_item(make_item(OP_PRIV_WRITE, reg_addr(1'b0, REG_STATUS, 2'd0), 8'hA5, 5'd0, 1'b0));
      // Enable everything in bank 0 byte 0: pending bit 0 rises.
      send_item(make_item(OP_BUS_WRITE, reg_addr(1'b0, REG_ENABLE, 2'd0), 8'hFF, 5'd0, 1'b0));
      // Latch line 0, raise and drop it: the status bit stays until acknowledged.
      send_item(make_item(OP_BUS_WRITE, reg_addr(1'b0, REG_LATCH, 2'd0), 8'h01, 5'd0, 1'b0));
      send_item(make_item(OP_LINE_LEVEL, 8'h00, 8'h00, 5'd0, 1'b1));
      send_item(make_item(OP_LINE_LEVEL, 8'h00, 8'h00, 5'd0, 1'b0));
      send_item(make_item(OP_BUS_WRITE, reg_addr(1'b0, REG_ACK, 2'd0), 8'hFF, 5'd0, 1'b0));
      // Invert the top lines of bank 1 only: a low level sets bank 1 status.
      send_item(make_item(OP_BUS_WRITE, reg_addr(1'b1, REG_INVERT, 2'd2), 8'h3F, 5'd0, 1'b0));
      send_item(make_item(OP_LINE_LEVEL, 8'h00, 8'h00, 5'd21, 1'b0));
      send_item(make_item(OP_LINE_PULSE, 8'h00, 8'h00, 5'd21, 1'b0));
      // Lines past the controller do nothing.
      send_item(make_item(OP_LINE_LEVEL, 8'h00, 8'h00, 5'd22, 1'b1));
      send_item(make_item(OP_LINE_PULSE, 8'hFF, 8'hFF, 5'd31, 1'b1));
      // Masked status: plain write dropped, privileged write ORs enable and status.
      send_item(make_item(OP_BUS_WRITE, reg_addr(1'b0, REG_MASKED, 2'd2), 8'hFF, 5'd0, 1'b0));
      send_item(make_item(OP_PRIV_WRITE, reg_addr(1'b1, REG_MASKED, 2'd2), 8'h20, 5'd0, 1'b0));
      send_item(make_item(OP_BUS_READ, reg_addr(1'b1, REG_MASKED, 2'd2), 8'h00, 5'd0, 1'b0));
      // Spare operation code with every other field at its top value.
      send_item(make_item(OP_UNUSED_HI, 8'hFF, 8'hFF, 5'd31, 1'b1));

      // ---- random part, three idling phases ----
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 30;
               recv_idle_pct = 65;
            end
            1: begin
               send_idle_pct = 65;
               recv_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Mid-way through the no-idle phase: long receiver hold-off while
            // the sender keeps offering transactions.
            if (phase == 2 && n == PHASE_ITEMS / 2)
               stall_requests++;
            pick = $urandom_range(99);
            if (pick < 30)      it.operation = OP_BUS_READ;
            else if (pick < 50) it.operation = OP_BUS_WRITE;
            else if (pick < 65) it.operation = OP_PRIV_WRITE;
            else if (pick < 83) it.operation = OP_LINE_LEVEL;
            else if (pick < 95) it.operation = OP_LINE_PULSE;
            else it.operation = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            // Mostly mapped registers; now and then any byte address.
            pick = $urandom_range(99);
            if (pick < 75)
               it.address = reg_addr(1'($urandom),
                                     reg_type'($urandom_range(REG_MASKED, REG_STATUS)),
                                     2'($urandom));
            else if (pick < 85)
               it.address = {($urandom_range(1) != 0) ? IDX_REVISION : IDX_SRC_COUNT,
                             2'($urandom)};
            else
               it.address = 8'($urandom);
            it.write_data  = 8'($urandom);
            it.source_line = ($urandom_range(99) < 85) ? 5'($urandom_range(SRC_COUNT - 1))
                                                       : 5'($urandom);
            it.line_level  = 1'($urandom);
            send_item(it);
         end
         // Sender pauses until every forecast response is back.
         req_ch.valid <= 1'b0;
         wait (open_results == 0);
         @(negedge clock);
      end

      // Drain, then wait for anything stray to show up.
      wait (open_results == 0);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
